FILE: sv/lpce_pkg.sv
// ----------------------------------------------------------------------------
// lpce_pkg
// Shared types, constants and tables for the LED pattern channel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpce_pkg;

    // Strip and table sizing
    localparam int LED_COUNT       = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam int CHAN_COUNT      = LED_COUNT * 3;

    // Field widths
    localparam int IDX_W      = 7;
    localparam int TIME_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int SYM_W      = 6;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_BREATH = 3'd0,
        MODE_WHEEL  = 3'd1,
        MODE_SLOT0  = 3'd2,
        MODE_SLOT1  = 3'd3,
        MODE_SLOT2  = 3'd4,
        MODE_ALL    = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_MODE     = 1'b0,
        CFG_BRIGHTNESS_LIMIT = 1'b1
    } t_cfg_reg;

    localparam logic [BYTE_W-1:0] BRIGHT_RESET = 8'd50;

    // UART symbol for each bit pair
    localparam logic [SYM_W-1:0] SYM_LUT [4] = '{6'b110111, 6'b000111, 6'b110100, 6'b000100};

    // Periods in ms
    localparam int BREATH_PERIOD = 15000;
    localparam int WHEEL_PERIOD  = 30000;
    localparam int WHEEL_SECTOR  = 5000;

    // t mod 30000: q_est = (t * W_RECIP) >> W_RECIP_SH is q or q-1
    localparam int          W_RECIP_SH = 46;
    localparam logic [31:0] W_RECIP    = 32'((64'd1 << W_RECIP_SH) / WHEEL_PERIOD);
    localparam int          QEST_W     = 18;
    localparam int          REM_W      = 16;   // remainder before correction, < 60000
    localparam int          R30_W      = 15;
    localparam int          R15_W      = 14;
    localparam int          SEC_W      = 3;

    // Breathing phase: floor((r15 << STB) / 15000), exact reciprocal
    localparam int PH_W        = SINE_TABLE_BITS;
    localparam int BN_W        = R15_W + PH_W;
    localparam int B_RECIP_SH  = 28 + PH_W;
    localparam int B_RECIP_W   = B_RECIP_SH - 13;
    localparam logic [B_RECIP_W-1:0] B_RECIP =
        B_RECIP_W'(((64'd1 << B_RECIP_SH) + 64'(BREATH_PERIOD - 1)) / BREATH_PERIOD);

    // Quarter-wave sine table
    localparam int QTR_W   = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QTR_W;
    localparam int SINE_W  = 17;

    // Hue ramp: floor(v * dd / 5000), exact reciprocal
    localparam int HD_W        = 13;
    localparam int HP_W        = 21;
    localparam int H_RECIP_SH  = 34;
    localparam int H_RECIP_W   = 22;
    localparam logic [H_RECIP_W-1:0] H_RECIP =
        H_RECIP_W'(((64'd1 << H_RECIP_SH) + 64'(WHEEL_SECTOR - 1)) / WHEEL_SECTOR);

    // idx / 3 as (idx * 43) >> 7, exact over 7-bit indexes
    localparam int DIV3_MUL = 43;
    localparam int DIV3_SH  = 7;

    // Odd polynomial to x^9, Q16, Horner form with truncating shifts, capped at 1.0
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        x  = longint'(q) << (16 - QTR_W);
        x2 = (x * x) >> 16;
        r  = 64'd307 - ((x2 * 64'd11) >> 16);
        r  = 64'd5223 - ((x2 * r) >> 16);
        r  = 64'd42334 - ((x2 * r) >> 16);
        r  = 64'd102944 - ((x2 * r) >> 16);
        r  = (x * r) >> 16;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return SINE_W'(r);
    endfunction

    typedef logic [SINE_W-1:0] t_sine_lut [QUARTER];

    function automatic t_sine_lut build_sine_lut();
        t_sine_lut lut;
        for (int i = 0; i < QUARTER; i++) begin
            lut[i] = quarter_sine(i);
        end
        return lut;
    endfunction

    localparam t_sine_lut         SINE_LUT  = build_sine_lut();
    localparam logic [SINE_W-1:0] SINE_PEAK = quarter_sine(QUARTER);

endpackage

`default_nettype wire

FILE: sv/lpce_in_if.sv
// ----------------------------------------------------------------------------
// lpce_in_if
// Request channel: one LED colour channel index and a millisecond time.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpce_in_if;
    logic                        valid;
    logic                        ready;
    logic [lpce_pkg::IDX_W-1:0]  channel_index;
    logic [lpce_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, output channel_index, output time_ms, input ready);
    modport sink   (input valid, input channel_index, input time_ms, output ready);
endinterface

`default_nettype wire

FILE: sv/lpce_out_if.sv
// ----------------------------------------------------------------------------
// lpce_out_if
// Result channel: channel brightness byte and its four UART symbols.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpce_out_if;
    logic                        valid;
    logic                        ready;
    logic [lpce_pkg::BYTE_W-1:0] channel_byte;
    logic [lpce_pkg::SYM_W-1:0]  symbol_bits_7_6;
    logic [lpce_pkg::SYM_W-1:0]  symbol_bits_5_4;
    logic [lpce_pkg::SYM_W-1:0]  symbol_bits_3_2;
    logic [lpce_pkg::SYM_W-1:0]  symbol_bits_1_0;

    modport source (output valid, output channel_byte, output symbol_bits_7_6,
                    output symbol_bits_5_4, output symbol_bits_3_2,
                    output symbol_bits_1_0, input ready);
    modport sink   (input valid, input channel_byte, input symbol_bits_7_6,
                    input symbol_bits_5_4, input symbol_bits_3_2,
                    input symbol_bits_1_0, output ready);
endinterface

`default_nettype wire

FILE: sv/led_pattern_channel_encoder.sv
// ----------------------------------------------------------------------------
// led_pattern_channel_encoder
// Computes one LED channel brightness byte from pattern mode and time, and
// encodes it as four 6-bit UART symbols, most significant bit pair first.
//
//   Channel   Dir   Handshake      Payload
//   i_in      in    valid/ready    channel_index[6:0], time_ms[31:0]
//   o_out     out   valid/ready    channel_byte[7:0], symbol_bits_*[5:0] x4
//   i_cfg_*   in    write enable   index 0 pattern_mode, index 1 brightness_limit
//
// Eight register stages. One request per cycle sustained while the output
// is not stalled; the stage count is set by the 32x32 reciprocal multiply
// for time mod 30000 and the multiply chains after it. Each stage holds
// while the stage after it is full and stalled; empty stages fill, so
// bubbles collapse. Synchronous reset empties the pipeline and loads
// pattern_mode 0 and brightness_limit 50.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_channel_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lpce_in_if.sink                         i_in,
    lpce_out_if.source                      o_out
);

    localparam int NSTG = 8;

    // Configuration
    logic [lpce_pkg::MODE_W-1:0] r_mode;
    logic [lpce_pkg::BYTE_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lpce_pkg::MODE_BREATH;
            r_limit <= lpce_pkg::BRIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpce_pkg::CFG_PATTERN_MODE:     r_mode  <= i_cfg_data[lpce_pkg::MODE_W-1:0];
                lpce_pkg::CFG_BRIGHTNESS_LIMIT: r_limit <= i_cfg_data[lpce_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic [NSTG-1:0] n_vld;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign n_vld       = {r_vld[NSTG-2:0], i_in.valid};
    assign i_in.ready  = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    // Stage 1: reciprocal multiply for t / 30000, slot = idx mod 3, range check
    logic [63:0]                   w_prod30;
    logic [13:0]                   w_div3;
    logic [lpce_pkg::IDX_W-1:0]    w_q3;
    logic [lpce_pkg::IDX_W-1:0]    w_q3x3;
    logic [lpce_pkg::IDX_W-1:0]    w_slot_full;

    logic [lpce_pkg::TIME_W-1:0]   r_s1_t;
    logic [lpce_pkg::QEST_W-1:0]   r_s1_qest;
    logic [1:0]                    r_s1_slot;
    logic                          r_s1_lit;

    assign w_prod30    = {32'd0, i_in.time_ms} * {32'd0, lpce_pkg::W_RECIP};
    assign w_div3      = 14'(i_in.channel_index) * 14'(lpce_pkg::DIV3_MUL);
    assign w_q3        = w_div3[lpce_pkg::DIV3_SH +: lpce_pkg::IDX_W];
    assign w_q3x3      = 7'(w_q3 * 7'd3);
    assign w_slot_full = i_in.channel_index - w_q3x3;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_t    <= i_in.time_ms;
            r_s1_qest <= w_prod30[lpce_pkg::W_RECIP_SH +: lpce_pkg::QEST_W];
            r_s1_slot <= w_slot_full[1:0];
            r_s1_lit  <= int'(i_in.channel_index) < lpce_pkg::CHAN_COUNT;
        end
    end

    // Stage 2: remainder estimate, below twice the period
    logic [32:0]                 w_qx;
    logic [32:0]                 w_rem;
    logic [lpce_pkg::REM_W-1:0]  r_s2_rem;
    logic [1:0]                  r_s2_slot;
    logic                        r_s2_lit;

    assign w_qx  = {15'd0, r_s1_qest} * 33'(lpce_pkg::WHEEL_PERIOD);
    assign w_rem = {1'b0, r_s1_t} - w_qx;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_rem  <= w_rem[lpce_pkg::REM_W-1:0];
            r_s2_slot <= r_s1_slot;
            r_s2_lit  <= r_s1_lit;
        end
    end

    // Stage 3: correct to t mod 30000
    logic [lpce_pkg::REM_W-1:0]  w_rem_c;
    logic [lpce_pkg::R30_W-1:0]  r_s3_r30;
    logic [1:0]                  r_s3_slot;
    logic                        r_s3_lit;

    assign w_rem_c = (r_s2_rem >= lpce_pkg::REM_W'(lpce_pkg::WHEEL_PERIOD))
                   ? r_s2_rem - lpce_pkg::REM_W'(lpce_pkg::WHEEL_PERIOD) : r_s2_rem;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_r30  <= w_rem_c[lpce_pkg::R30_W-1:0];
            r_s3_slot <= r_s2_slot;
            r_s3_lit  <= r_s2_lit;
        end
    end

    // Stage 4: t mod 15000 and hue sector
    logic [lpce_pkg::R30_W-1:0]  w_r15;
    logic [lpce_pkg::SEC_W-1:0]  w_sec;
    logic [lpce_pkg::R15_W-1:0]  r_s4_r15;
    logic [lpce_pkg::R30_W-1:0]  r_s4_r30;
    logic [lpce_pkg::SEC_W-1:0]  r_s4_sec;
    logic [1:0]                  r_s4_slot;
    logic                        r_s4_lit;

    assign w_r15 = (r_s3_r30 >= lpce_pkg::R30_W'(lpce_pkg::BREATH_PERIOD))
                 ? r_s3_r30 - lpce_pkg::R30_W'(lpce_pkg::BREATH_PERIOD) : r_s3_r30;

    always_comb begin
        w_sec = '0;
        for (int i = 1; i < 6; i++) begin
            w_sec = w_sec + lpce_pkg::SEC_W'(r_s3_r30 >=
                                             lpce_pkg::R30_W'(i * lpce_pkg::WHEEL_SECTOR));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_r15  <= w_r15[lpce_pkg::R15_W-1:0];
            r_s4_r30  <= r_s3_r30;
            r_s4_sec  <= w_sec;
            r_s4_slot <= r_s3_slot;
            r_s4_lit  <= r_s3_lit;
        end
    end

    // Stage 5: breathing phase by reciprocal multiply; hue ramp distance
    localparam int BP_W = lpce_pkg::BN_W + lpce_pkg::B_RECIP_W;

    logic [lpce_pkg::BN_W-1:0]   w_bn;
    logic [BP_W-1:0]             w_bprod;
    logic [lpce_pkg::R30_W-1:0]  w_lo;
    logic [lpce_pkg::R30_W-1:0]  w_hi;
    logic [lpce_pkg::R30_W-1:0]  w_hd;

    logic [lpce_pkg::PH_W-1:0]   r_s5_ph;
    logic [lpce_pkg::HD_W-1:0]   r_s5_hd;
    logic [lpce_pkg::SEC_W-1:0]  r_s5_sec;
    logic [1:0]                  r_s5_slot;
    logic                        r_s5_lit;

    assign w_bn    = {r_s4_r15, lpce_pkg::PH_W'(0)};
    assign w_bprod = BP_W'(w_bn) * BP_W'(lpce_pkg::B_RECIP);
    assign w_lo    = lpce_pkg::R30_W'(int'(r_s4_sec) * lpce_pkg::WHEEL_SECTOR);
    assign w_hi    = lpce_pkg::R30_W'((int'(r_s4_sec) + 1) * lpce_pkg::WHEEL_SECTOR);
    // odd sectors ramp down: 5000 - d = sector end - r
    assign w_hd    = r_s4_sec[0] ? w_hi - r_s4_r30 : r_s4_r30 - w_lo;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_ph   <= w_bprod[lpce_pkg::B_RECIP_SH +: lpce_pkg::PH_W];
            r_s5_hd   <= w_hd[lpce_pkg::HD_W-1:0];
            r_s5_sec  <= r_s4_sec;
            r_s5_slot <= r_s4_slot;
            r_s5_lit  <= r_s4_lit;
        end
    end

    // Stage 6: quarter-wave sine lookup; limit * ramp distance
    logic [1:0]                  w_quad;
    logic [lpce_pkg::QTR_W-1:0]  w_q;
    logic                        w_use_q;
    logic [lpce_pkg::QTR_W:0]    w_sidx;
    logic [lpce_pkg::SINE_W-1:0] w_sine;

    logic [lpce_pkg::SINE_W-1:0] r_s6_sine;
    logic [lpce_pkg::HP_W-1:0]   r_s6_hprod;
    logic [lpce_pkg::SEC_W-1:0]  r_s6_sec;
    logic [1:0]                  r_s6_slot;
    logic                        r_s6_lit;

    assign w_quad  = r_s5_ph[lpce_pkg::PH_W-1 -: 2];
    assign w_q     = r_s5_ph[lpce_pkg::QTR_W-1:0];
    // slot 1 takes |sin|, mirroring the index in odd quadrants; slot 2 |cos|, mirroring in even ones
    assign w_use_q = (r_s5_slot == 2'd1) ? !w_quad[0] : w_quad[0];
    assign w_sidx  = w_use_q ? {1'b0, w_q}
                             : (lpce_pkg::QTR_W+1)'(lpce_pkg::QUARTER) - {1'b0, w_q};
    assign w_sine  = w_sidx[lpce_pkg::QTR_W] ? lpce_pkg::SINE_PEAK
                                             : lpce_pkg::SINE_LUT[w_sidx[lpce_pkg::QTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_sine  <= w_sine;
            r_s6_hprod <= lpce_pkg::HP_W'(r_limit) * lpce_pkg::HP_W'(r_s5_hd);
            r_s6_sec   <= r_s5_sec;
            r_s6_slot  <= r_s5_slot;
            r_s6_lit   <= r_s5_lit;
        end
    end

    // Stage 7: breathing byte; ramp / 5000
    localparam int SP_W = lpce_pkg::SINE_W + lpce_pkg::BYTE_W;
    localparam int HQ_W = lpce_pkg::HP_W + lpce_pkg::H_RECIP_W;

    logic [SP_W-1:0]             w_sprod;
    logic [HQ_W-1:0]             w_hq;

    logic [lpce_pkg::BYTE_W-1:0] r_s7_breath;
    logic [lpce_pkg::BYTE_W-1:0] r_s7_ramp;
    logic [lpce_pkg::SEC_W-1:0]  r_s7_sec;
    logic [1:0]                  r_s7_slot;
    logic                        r_s7_lit;

    assign w_sprod = SP_W'(r_limit) * SP_W'(r_s6_sine);
    assign w_hq    = HQ_W'(r_s6_hprod) * HQ_W'(lpce_pkg::H_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s7_breath <= w_sprod[16 +: lpce_pkg::BYTE_W];
            r_s7_ramp   <= w_hq[lpce_pkg::H_RECIP_SH +: lpce_pkg::BYTE_W];
            r_s7_sec    <= r_s6_sec;
            r_s7_slot   <= r_s6_slot;
            r_s7_lit    <= r_s6_lit;
        end
    end

    // Stage 8: pattern select and symbol encode into the output register
    logic [lpce_pkg::BYTE_W-1:0] w_a;
    logic [lpce_pkg::BYTE_W-1:0] w_b;
    logic [lpce_pkg::BYTE_W-1:0] w_c;
    logic [lpce_pkg::BYTE_W-1:0] w_wheel;
    logic [lpce_pkg::BYTE_W-1:0] w_byte;

    logic [lpce_pkg::BYTE_W-1:0] r_s8_byte;
    logic [lpce_pkg::SYM_W-1:0]  r_s8_sym76;
    logic [lpce_pkg::SYM_W-1:0]  r_s8_sym54;
    logic [lpce_pkg::SYM_W-1:0]  r_s8_sym32;
    logic [lpce_pkg::SYM_W-1:0]  r_s8_sym10;

    always_comb begin
        case (r_s7_sec)
            3'd0:    begin w_a = r_limit;   w_b = r_s7_ramp; w_c = '0;        end
            3'd1:    begin w_a = r_s7_ramp; w_b = r_limit;   w_c = '0;        end
            3'd2:    begin w_a = '0;        w_b = r_limit;   w_c = r_s7_ramp; end
            3'd3:    begin w_a = '0;        w_b = r_s7_ramp; w_c = r_limit;   end
            3'd4:    begin w_a = r_s7_ramp; w_b = '0;        w_c = r_limit;   end
            default: begin w_a = r_limit;   w_b = '0;        w_c = r_s7_ramp; end
        endcase

        // slot 2 <- A, slot 0 <- B, slot 1 <- C
        case (r_s7_slot)
            2'd2:    w_wheel = w_a;
            2'd0:    w_wheel = w_b;
            default: w_wheel = w_c;
        endcase

        unique case (r_mode)
            lpce_pkg::MODE_BREATH: w_byte = (r_s7_slot == 2'd0) ? '0 : r_s7_breath;
            lpce_pkg::MODE_WHEEL:  w_byte = w_wheel;
            lpce_pkg::MODE_SLOT0:  w_byte = (r_s7_slot == 2'd0) ? r_limit : '0;
            lpce_pkg::MODE_SLOT1:  w_byte = (r_s7_slot == 2'd1) ? r_limit : '0;
            lpce_pkg::MODE_SLOT2:  w_byte = (r_s7_slot == 2'd2) ? r_limit : '0;
            lpce_pkg::MODE_ALL:    w_byte = r_limit;
            default:               w_byte = '0;
        endcase

        if (!r_s7_lit) begin
            w_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s8_byte  <= w_byte;
            r_s8_sym76 <= lpce_pkg::SYM_LUT[w_byte[7:6]];
            r_s8_sym54 <= lpce_pkg::SYM_LUT[w_byte[5:4]];
            r_s8_sym32 <= lpce_pkg::SYM_LUT[w_byte[3:2]];
            r_s8_sym10 <= lpce_pkg::SYM_LUT[w_byte[1:0]];
        end
    end

    assign o_out.valid           = r_vld[NSTG-1];
    assign o_out.channel_byte    = r_s8_byte;
    assign o_out.symbol_bits_7_6 = r_s8_sym76;
    assign o_out.symbol_bits_5_4 = r_s8_sym54;
    assign o_out.symbol_bits_3_2 = r_s8_sym32;
    assign o_out.symbol_bits_1_0 = r_s8_sym10;

endmodule

`default_nettype wire

FILE: sv/lpce_checker.sv
// ----------------------------------------------------------------------------
// lpce_port_checks
// Port-level checks for the LED pattern channel encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lpce_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [lpce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [lpce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [lpce_pkg::BYTE_W-1:0]     i_out_byte,
    input logic [lpce_pkg::SYM_W-1:0]      i_out_sym76,
    input logic [lpce_pkg::SYM_W-1:0]      i_out_sym54,
    input logic [lpce_pkg::SYM_W-1:0]      i_out_sym32,
    input logic [lpce_pkg::SYM_W-1:0]      i_out_sym10
);

    // shadow of the brightness limit, seen from the write port
    logic [lpce_pkg::BYTE_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lpce_pkg::BRIGHT_RESET;
        end else if (i_cfg_we && i_cfg_idx == lpce_pkg::CFG_BRIGHTNESS_LIMIT) begin
            r_limit <= i_cfg_data[lpce_pkg::BYTE_W-1:0];
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_symbols_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_sym76 == lpce_pkg::SYM_LUT[i_out_byte[7:6]]
                     && i_out_sym54 == lpce_pkg::SYM_LUT[i_out_byte[5:4]]
                     && i_out_sym32 == lpce_pkg::SYM_LUT[i_out_byte[3:2]]
                     && i_out_sym10 == lpce_pkg::SYM_LUT[i_out_byte[1:0]])
        else $error("symbols do not encode the channel byte");

    a_byte_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_byte <= r_limit)
        else $error("channel byte above brightness limit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled result changed");

endmodule

bind led_pattern_channel_encoder lpce_port_checks u_lpce_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.channel_byte),
    .i_out_sym76 (o_out.symbol_bits_7_6),
    .i_out_sym54 (o_out.symbol_bits_5_4),
    .i_out_sym32 (o_out.symbol_bits_3_2),
    .i_out_sym10 (o_out.symbol_bits_1_0)
);

`default_nettype wire
